// ===== rtl/core/mtg_pkg.sv =====
package mtg_pkg;

  // Table geometry.
  localparam int unsigned TableWords   = 624;
  localparam int unsigned MiddleOffset = 397;
  localparam int unsigned AddrW        = $clog2(TableWords);
  localparam int unsigned IdxW         = $clog2(TableWords + 2);
  localparam int unsigned WordW        = 32;

  // Read index codes: a full table waits for a twist, one past that was never seeded.
  localparam logic [IdxW-1:0]  IdxSeeded   = IdxW'(TableWords);
  localparam logic [IdxW-1:0]  IdxUnseeded = IdxW'(TableWords + 1);
  localparam logic [AddrW-1:0] LastAddr    = AddrW'(TableWords - 1);
  localparam logic [AddrW-1:0] WrapPoint   = AddrW'(TableWords - MiddleOffset);
  localparam logic [AddrW-1:0] MidStep     = AddrW'(MiddleOffset);

  // Generator constants.
  localparam logic [WordW-1:0] SeedMult    = 32'd1812433253;
  localparam logic [WordW-1:0] DefaultSeed = 32'd5489;
  localparam logic [WordW-1:0] TwistXor    = 32'h9908_b0df;
  localparam logic [WordW-1:0] TemperB     = 32'h9d2c_5680;
  localparam logic [WordW-1:0] TemperC     = 32'hefc6_0000;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_RAW    = 2'd0,
    OP_RANGE  = 2'd1,
    OP_RESEED = 2'd2
  } mtg_op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_TW_PRIME,
    ST_TW_HI,
    ST_TW_RD,
    ST_TW_WR,
    ST_RD,
    ST_TEMPER,
    ST_MOD,
    ST_OUT
  } mtg_state_e;

  // Status of the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mtg_div_stat_t;

  // Output tempering of one table word.
  function automatic logic [WordW-1:0] mtg_temper(input logic [WordW-1:0] w);
    logic [WordW-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== rtl/core/mtg_ram.sv =====
module mtg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mtg_mod.sv =====
module mtg_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mtg_pkg::WordW-1:0]   dividend_i,
  input  logic [mtg_pkg::WordW-1:0]   divisor_i,
  output mtg_pkg::mtg_div_stat_t      stat_o,
  output logic [mtg_pkg::WordW-1:0]   rem_o
);
  import mtg_pkg::*;

  localparam int unsigned CntW = $clog2(WordW);

  logic [WordW-1:0] dvd_q, dvd_d;
  logic [WordW-1:0] dsr_q, dsr_d;
  logic [WordW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WordW:0]   shifted;
  logic [WordW:0]   diff;

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  assign shifted = {rem_q, dvd_q[WordW-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[WordW-2:0], 1'b0};
      rem_d = diff[WordW] ? shifted[WordW-1:0] : diff[WordW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {CntW{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and remainder registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

// ===== rtl/core/mersenne_twister_generator_core.sv =====
// Channel   Direction  Handshake                  Payload
// request   in         in_valid_i / in_stall_o    opcode_i, seed_i, range_low_i, range_high_i
// result    out        out_valid_o / out_stall_i  value_o, range_error_o
//
// A raw word from a twisted table is read, tempered and then loaded into the output register;
// a ranged word also passes through the bit-serial remainder unit.
// Twisting and seeding the table both go through the table memories one word at a time,
// with a read and a write state or a multiply and an add state for each word.
// After reset the table is unseeded; the first raw or ranged request seeds it with 5489.
// A new request transfers once the previous result sits in the output register,
// which holds its value while out_stall_i is high.
module mersenne_twister_generator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                opcode_i,
  input  logic [mtg_pkg::WordW-1:0] seed_i,
  input  logic [mtg_pkg::WordW-1:0] range_low_i,
  input  logic [mtg_pkg::WordW-1:0] range_high_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [mtg_pkg::WordW-1:0] value_o,
  output logic                      range_error_o
);
  import mtg_pkg::*;

  mtg_state_e       state_q, state_d;
  logic [1:0]       op_q;
  logic [WordW-1:0] lo_q, hi_q;
  logic [IdxW-1:0]  read_index_q, read_index_d;
  logic [AddrW-1:0] k_q;
  logic [WordW-1:0] p_q, prod_q;
  logic             cur_hi_q;
  logic [WordW-1:0] res_value_q;
  logic             res_err_q;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_value_q;
  logic             out_err_q;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, raddr_a, raddr_b;
  logic [WordW-1:0] ram_wdata, rdata_a, rdata_b;
  logic [AddrW-1:0] nxt_addr, mid_addr;
  logic [WordW-1:0] y_mix, twist_word, tempered, width, div_rem;
  logic             width_zero, div_start, out_load;
  mtg_div_stat_t    div_stat;

  // Two copies of the table, written together, so that a twist step reads two words at once.
  mtg_ram #(.Width(WordW), .Depth(TableWords)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mtg_ram #(.Width(WordW), .Depth(TableWords)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // Remainder unit for ranged words.
  mtg_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tempered),
    .divisor_i  (width),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  // Twist neighbors of the current entry and the twisted word itself.
  assign nxt_addr   = (k_q == LastAddr) ? '0 : k_q + 1'b1;
  assign mid_addr   = (k_q < WrapPoint) ? k_q + MidStep : k_q - WrapPoint;
  assign y_mix      = {cur_hi_q, rdata_a[WordW-2:0]};
  assign twist_word = rdata_b ^ (y_mix >> 1) ^ (y_mix[0] ? TwistXor : '0);

  // Output tempering and range width.
  assign tempered   = mtg_temper(rdata_a);
  assign width      = hi_q - lo_q;
  assign width_zero = (width == '0);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_RESEED: state_d = ST_SEED_MUL;
            OP_RAW, OP_RANGE: begin
              if (read_index_q == IdxUnseeded) begin
                state_d = ST_SEED_MUL;
              end else if (read_index_q == IdxSeeded) begin
                state_d = ST_TW_PRIME;
              end else begin
                state_d = ST_RD;
              end
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_SEED_MUL: begin
        if (k_q == LastAddr) begin
          state_d = (op_q == OP_RESEED) ? ST_OUT : ST_TW_PRIME;
        end else begin
          state_d = ST_SEED_ADD;
        end
      end
      ST_SEED_ADD: state_d = ST_SEED_MUL;
      ST_TW_PRIME: state_d = ST_TW_HI;
      ST_TW_HI:    state_d = ST_TW_WR;
      ST_TW_RD:    state_d = ST_TW_WR;
      ST_TW_WR:    state_d = (k_q == LastAddr) ? ST_RD : ST_TW_RD;
      ST_RD:       state_d = ST_TEMPER;
      ST_TEMPER:   state_d = ((op_q == OP_RANGE) && !width_zero) ? ST_MOD : ST_OUT;
      ST_MOD: begin
        if (div_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory and unit controls per state.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = k_q;
    ram_wdata  = p_q;
    ram_re     = 1'b0;
    raddr_a    = nxt_addr;
    raddr_b    = mid_addr;
    div_start  = 1'b0;
    case (state_q)
      ST_SEED_MUL: ram_we = 1'b1;
      ST_TW_PRIME: begin
        ram_re  = 1'b1;
        raddr_a = '0;
      end
      ST_TW_HI, ST_TW_RD: ram_re = 1'b1;
      ST_TW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = twist_word;
      end
      ST_RD: begin
        ram_re  = 1'b1;
        raddr_a = read_index_q[AddrW-1:0];
      end
      ST_TEMPER: div_start = (op_q == OP_RANGE) && !width_zero;
      default: ;
    endcase
  end

  // Read index and output valid.
  always_comb begin
    read_index_d = read_index_q;
    if ((state_q == ST_SEED_MUL) && (k_q == LastAddr)) begin
      read_index_d = IdxSeeded;
    end else if ((state_q == ST_TW_WR) && (k_q == LastAddr)) begin
      read_index_d = '0;
    end else if (state_q == ST_TEMPER) begin
      read_index_d = read_index_q + 1'b1;
    end
    out_valid_d = out_load | (out_valid_q & out_stall_i);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      read_index_q <= IdxUnseeded;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      read_index_q <= read_index_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Request, seeding, twisting and result registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_q        <= opcode_i;
          lo_q        <= range_low_i;
          hi_q        <= range_high_i;
          k_q         <= '0;
          p_q         <= (opcode_i == OP_RESEED) ? seed_i : DefaultSeed;
          res_value_q <= '0;
          res_err_q   <= 1'b0;
        end
      end
      ST_SEED_MUL: prod_q <= SeedMult * (p_q ^ (p_q >> 30));
      ST_SEED_ADD: begin
        p_q <= prod_q + WordW'(k_q) + 1'b1;
        k_q <= k_q + 1'b1;
      end
      ST_TW_PRIME: k_q <= '0;
      ST_TW_HI:    cur_hi_q <= rdata_a[WordW-1];
      ST_TW_WR: begin
        cur_hi_q <= rdata_a[WordW-1];
        k_q      <= k_q + 1'b1;
      end
      ST_TEMPER: begin
        res_value_q <= (op_q == OP_RANGE) ? '0 : tempered;
        res_err_q   <= (op_q == OP_RANGE) && width_zero;
      end
      ST_MOD: begin
        if (div_stat.done) begin
          res_value_q <= div_rem + lo_q;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_value_q <= res_value_q;
          out_err_q   <= res_err_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = out_value_q;
  assign range_error_o = out_err_q;

`ifndef SYNTH
  // The read index never goes past the unseeded code.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_index_q <= IdxUnseeded)
    else $error("read index out of range");

  // A word is only drawn from a table that holds fresh words.
  a_draw_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD |-> read_index_q < IdxSeeded)
    else $error("word drawn from an exhausted table");

  // The table is written only while seeding or twisting.
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SEED_MUL || state_q == ST_TW_WR))
    else $error("table written outside seeding or twisting");

  // The remainder unit finishes only while the sequencer waits for it.
  a_mod_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_MOD)
    else $error("remainder finished outside its wait state");

  // A start sets the remainder unit busy.
  a_mod_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_stat.busy)
    else $error("remainder unit did not start");
`endif

endmodule

// ===== bench/mtg_checker.sv =====
module mtg_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [1:0]                opcode_i,
  input  logic [mtg_pkg::WordW-1:0] seed_i,
  input  logic [mtg_pkg::WordW-1:0] range_low_i,
  input  logic [mtg_pkg::WordW-1:0] range_high_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [mtg_pkg::WordW-1:0] value_i,
  input  logic                      range_error_i,
  output int                        mismatch_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mtg_pkg::*;

  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [WordW-1:0] value;
    logic             range_error;
  } drawn_result_t;

  // Private copy of the generator state.
  logic [WordW-1:0] twist_tbl [TableWords];
  int unsigned      draw_idx;

  // Results predicted for transfers already taken, oldest first.
  drawn_result_t    expected_words [$];

  // Fill the table from a seed with the multiplier recurrence.
  function automatic void fill_from_seed(input logic [WordW-1:0] s);
    logic [WordW-1:0] p;
    twist_tbl[0] = s;
    for (int unsigned i = 1; i < TableWords; i++) begin
      p = twist_tbl[i-1];
      twist_tbl[i] = SeedMult * (p ^ (p >> 30)) + WordW'(i);
    end
    draw_idx = TableWords;
  endfunction

  // Regenerate every table word in place.
  function automatic void regenerate_table();
    logic [WordW-1:0] y;
    int unsigned      nxt;
    int unsigned      mid;
    for (int unsigned k = 0; k < TableWords; k++) begin
      nxt = (k + 1) % TableWords;
      mid = (k + MiddleOffset) % TableWords;
      y = (twist_tbl[k] & 32'h8000_0000) | (twist_tbl[nxt] & 32'h7fff_ffff);
      twist_tbl[k] = twist_tbl[mid] ^ (y >> 1) ^ (y[0] ? TwistXor : '0);
    end
    draw_idx = 0;
  endfunction

  // Next tempered word; seeds with the default on first use and twists when exhausted.
  function automatic logic [WordW-1:0] draw_tempered();
    logic [WordW-1:0] y;
    if (draw_idx >= TableWords) begin
      if (draw_idx != TableWords) fill_from_seed(DefaultSeed);
      regenerate_table();
    end
    y = twist_tbl[draw_idx];
    draw_idx++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Predict on each request transfer and compare on each result transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    drawn_result_t    exp_res;
    drawn_result_t    got_res;
    logic [WordW-1:0] word;
    logic [WordW-1:0] span;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < TableWords; i++) twist_tbl[i] = '0;
      draw_idx = TableWords + 1;
      expected_words.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        exp_res.value = '0;
        exp_res.range_error = 1'b0;
        case (mtg_op_e'(opcode_i))
          OP_RAW: begin
            exp_res.value = draw_tempered();
          end
          OP_RANGE: begin
            word = draw_tempered();
            span = range_high_i - range_low_i;
            if (span == '0) begin
              exp_res.range_error = 1'b1;
            end else begin
              exp_res.value = (word % span) + range_low_i;
            end
          end
          OP_RESEED: begin
            fill_from_seed(seed_i);
          end
          default: begin
          end
        endcase
        expected_words.push_back(exp_res);
      end

      if (out_valid_i && !out_stall_i) begin
        got_res.value = value_i;
        got_res.range_error = range_error_i;
        if (expected_words.size() == 0) begin
          if (mismatch_count_o < MaxReports)
            $display("%0t: result transfer with nothing expected: value %h error %b",
                     $realtime, got_res.value, got_res.range_error);
          mismatch_count_o++;
        end else begin
          exp_res = expected_words.pop_front();
          if (got_res.value !== exp_res.value ||
              got_res.range_error !== exp_res.range_error) begin
            if (mismatch_count_o < MaxReports)
              $display("%0t: result mismatch: expected value %h error %b, got value %h error %b",
                       $realtime, exp_res.value, exp_res.range_error,
                       got_res.value, got_res.range_error);
            mismatch_count_o++;
          end
        end
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mtg_pkg::*;

  localparam int HoldCycles  = 120;
  localparam int SettleCycles = 60;

  logic             clk_i;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  mtg_op_e          opcode;
  logic [WordW-1:0] seed;
  logic [WordW-1:0] range_low;
  logic [WordW-1:0] range_high;
  logic             out_valid;
  logic             out_stall;
  logic [WordW-1:0] value;
  logic             range_error;
  int               mismatch_count;
  int               pending;

  int unsigned      send_idle_pct;
  int unsigned      stall_pct;
  int unsigned      hold_reqs;
  int unsigned      holds_served;
  int unsigned      n_raw;
  int unsigned      n_range;
  int unsigned      n_reseed;

  // Clock with an 8 ns period.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  mersenne_twister_generator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .seed_i        (seed),
    .range_low_i   (range_low),
    .range_high_i  (range_high),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .value_o       (value),
    .range_error_o (range_error)
  );

  mtg_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .opcode_i         (opcode),
    .seed_i           (seed),
    .range_low_i      (range_low),
    .range_high_i     (range_high),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .value_i          (value),
    .range_error_i    (range_error),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Offer one request after a random gap and hold it until the transfer.
  task automatic send_req(input mtg_op_e op, input logic [WordW-1:0] s,
                          input logic [WordW-1:0] lo, input logic [WordW-1:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid   = 1'b1;
    opcode     = op;
    seed       = s;
    range_low  = lo;
    range_high = hi;
    do @(posedge clk_i); while (in_stall);
    case (op)
      OP_RAW:   n_raw++;
      OP_RANGE: n_range++;
      default:  n_reseed++;
    endcase
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Result side: random stalls, plus long hold-offs on request.
  initial begin
    out_stall = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_served) begin
        holds_served++;
        out_stall = 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Request side: reset, directed cases, then random phases.
  initial begin : stimulus
    int unsigned      idle_tab   [4];
    int unsigned      stall_tab  [4];
    int unsigned      count_tab  [4];
    int unsigned      reseed_pct;
    int unsigned      shape;
    mtg_op_e          op;
    logic [WordW-1:0] lo;
    logic [WordW-1:0] hi;
    idle_tab  = '{0, 76, 0, 33};
    stall_tab = '{0, 0, 76, 33};
    count_tab = '{700, 300, 300, 300};
    rst_n = 1'b0;
    in_valid = 1'b0;
    opcode = OP_RAW;
    seed = '0;
    range_low = '0;
    range_high = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    n_raw = 0;
    n_range = 0;
    n_reseed = 0;
    repeat (4) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Directed: default seeding on first draw, seed extremes, range corner cases.
    send_req(OP_RAW,    '0, '0, '0);
    send_req(OP_RANGE,  '1, 32'h0000_0000, 32'hffff_ffff);
    send_req(OP_RANGE,  '0, 32'h0000_0005, 32'h0000_0005);
    send_req(OP_RANGE,  '0, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_RANGE,  '0, 32'hffff_ffff, 32'hffff_ffff);
    send_req(OP_RANGE,  '0, 32'hffff_ffff, 32'h0000_0000);
    send_req(OP_RANGE,  '0, 32'h0000_0064, 32'h0000_0032);
    send_req(OP_RANGE,  '0, 32'h8000_0000, 32'h7fff_ffff);
    send_req(OP_RANGE,  '0, 32'h0000_0000, 32'h0000_0001);
    send_req(OP_RANGE,  '0, 32'hffff_fff0, 32'hffff_ffff);
    send_req(OP_RESEED, 32'h0000_0000, '1, '1);
    send_req(OP_RAW,    '1, '1, '1);
    send_req(OP_RESEED, 32'hffff_ffff, '0, '0);
    send_req(OP_RAW,    '0, '0, '0);
    send_req(OP_RANGE,  '0, 32'h0000_0000, 32'h0000_0007);
    send_req(OP_RESEED, DefaultSeed, '0, '0);
    send_req(OP_RESEED, $urandom, $urandom, $urandom);
    send_req(OP_RAW,    $urandom, $urandom, $urandom);
    send_req(OP_RANGE,  $urandom, $urandom, $urandom);
    wait_drained();

    // Random phases: the first runs long without reseeding so the table twists again.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      reseed_pct = (ph == 0) ? 0 : 1;
      for (int unsigned k = 0; k < count_tab[ph]; k++) begin
        if (k == 150) hold_reqs++;
        shape = $urandom_range(9);
        lo = $urandom;
        hi = $urandom;
        if (shape == 0) begin
          hi = lo;
        end else if (shape <= 2) begin
          hi = lo + $urandom_range(1, 16);
        end else if (shape == 3) begin
          lo = $urandom_range(0, 15);
        end
        if ($urandom_range(99) < reseed_pct) begin
          op = OP_RESEED;
        end else if ($urandom_range(1) == 0) begin
          op = OP_RAW;
        end else begin
          op = OP_RANGE;
        end
        send_req(op, $urandom, lo, hi);
      end
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d raw, %0d ranged and %0d reseed requests", n_raw, n_range, n_reseed);
    $display("over free-running, idle-sender, stalled-receiver and mixed flow phases.");
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== mersenne_twister_generator_core.f =====
rtl/core/mtg_pkg.sv
rtl/core/mtg_ram.sv
rtl/core/mtg_mod.sv
rtl/core/mersenne_twister_generator_core.sv
bench/mtg_checker.sv
bench/testbench.sv
